// ===== hdl/isu_pkg.sv =====
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types, codes and defaults for the indexed sequence store unit.
// ----------------------------------------------------------------------------
package isu_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam logic [2:0] OP_READ   = 3'd0;
   localparam logic [2:0] OP_HEAD   = 3'd1;
   localparam logic [2:0] OP_TAIL   = 3'd2;
   localparam logic [2:0] OP_AT     = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]         operation;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [6:0]         length;
   } rsp_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_READ,
      ACT_INSERT,
      ACT_DELETE
   } action_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_PREV,
      RD_NEXT
   } rdsel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_INS,
      S_INS_WR,
      S_DEL,
      S_DEL_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic      load;
      logic      check;
      logic      take_read;
      logic      ins_step;
      logic      del_step;
      logic      ins_final;
      logic      del_final;
      rdsel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       ins_more;
      logic       del_more;
   } stat_type;

endpackage

// ===== hdl/isu_ram.sv =====
// ----------------------------------------------------------------------------
// isu_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module isu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/isu_datapath.sv =====
// ----------------------------------------------------------------------------
// isu_datapath
// Element store, count, shift pointer, request decode and response registers.
// ----------------------------------------------------------------------------
module isu_datapath import isu_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int MW = (CW > 7) ? CW : 7;

   logic [2:0]    op_ff,    op_in;
   logic [6:0]    pos_ff,   pos_in;
   logic [31:0]   val_ff,   val_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff,   ptr_in;
   logic [CW-1:0] tgt_ff,   tgt_in;
   logic [31:0]   rv_ff,    rv_in;
   logic [1:0]    st_ff,    st_in;

   logic [MW-1:0] pos_x;
   logic [MW-1:0] cnt_x;
   logic          full;
   action_type    action;
   logic [1:0]    dec_st;
   logic [31:0]   dec_rv;
   logic [CW-1:0] dec_tgt;
   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] ptr_inc;
   logic [CW:0]   ptr_inc_x;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [31:0]   ram_rdata;

   assign pos_x     = MW'(pos_ff);
   assign cnt_x     = MW'(count_ff);
   assign full      = count_ff >= CW'(CAPACITY);
   assign ptr_dec   = ptr_ff - CW'(1);
   assign ptr_inc   = ptr_ff + CW'(1);
   assign ptr_inc_x = {1'b0, ptr_ff} + (CW + 1)'(1);

   // decode the held request against the current count
   always_comb begin
      action  = ACT_NONE;
      dec_st  = ST_DONE;
      dec_rv  = '0;
      dec_tgt = CW'(pos_x);
      case (op_ff)
         OP_READ: begin
            if (pos_x < cnt_x) begin
               action = ACT_READ;
            end else begin
               dec_st = ST_RANGE;
               dec_rv = READ_MISS;
            end
         end
         OP_HEAD: begin
            dec_tgt = '0;
            if (full) begin
               dec_st = ST_FULL;
            end else begin
               action = ACT_INSERT;
            end
         end
         OP_TAIL: begin
            dec_tgt = count_ff;
            if (full) begin
               dec_st = ST_FULL;
            end else begin
               action = ACT_INSERT;
            end
         end
         OP_AT: begin
            if (pos_x > cnt_x) begin
               dec_st = ST_RANGE;
            end else if (full) begin
               dec_st = ST_FULL;
            end else begin
               action = ACT_INSERT;
            end
         end
         OP_DELETE: begin
            if (pos_x < cnt_x) begin
               action = ACT_DELETE;
            end else begin
               dec_st = ST_RANGE;
            end
         end
         default: begin
            dec_st = ST_RANGE;
         end
      endcase
   end

   assign stat.action   = action;
   assign stat.ins_more = ptr_ff > tgt_ff;
   assign stat.del_more = ptr_inc_x < {1'b0, count_ff};

   always_comb begin
      op_in    = op_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      tgt_in   = tgt_ff;
      rv_in    = rv_ff;
      st_in    = st_ff;
      if (cmd.load) begin
         op_in  = req_data.operation;
         pos_in = req_data.position;
         val_in = req_data.value;
      end
      if (cmd.check) begin
         tgt_in = dec_tgt;
         ptr_in = (action == ACT_INSERT) ? count_ff : dec_tgt;
         st_in  = dec_st;
         rv_in  = dec_rv;
      end
      if (cmd.take_read) begin
         rv_in = ram_rdata;
      end
      if (cmd.ins_step) begin
         ptr_in = ptr_dec;
      end
      if (cmd.del_step) begin
         ptr_in = ptr_inc;
      end
      if (cmd.ins_final) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.del_final) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      ptr_ff <= ptr_in;
      tgt_ff <= tgt_in;
      rv_ff  <= rv_in;
      st_ff  <= st_in;
   end

   assign ram_we    = cmd.ins_step | cmd.del_step | cmd.ins_final;
   assign ram_waddr = cmd.ins_final ? tgt_ff[AW-1:0] : ptr_ff[AW-1:0];
   assign ram_wdata = cmd.ins_final ? val_ff : ram_rdata;

   always_comb begin
      case (cmd.rd_sel)
         RD_POS:  ram_raddr = AW'(pos_ff);
         RD_PREV: ram_raddr = ptr_dec[AW-1:0];
         RD_NEXT: ram_raddr = ptr_inc[AW-1:0];
         default: ram_raddr = AW'(pos_ff);
      endcase
   end

   isu_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_data.read_value = rv_ff;
   assign rsp_data.status     = st_ff;
   assign rsp_data.length     = cnt_x[6:0];

endmodule

// ===== hdl/isu_controller.sv =====
// ----------------------------------------------------------------------------
// isu_controller
// Sequencer for request decode, element reads and one-place shift sweeps.
// ----------------------------------------------------------------------------
module isu_controller import isu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (stat.action)
               ACT_READ:   state_in = S_READ;
               ACT_INSERT: state_in = S_INS;
               ACT_DELETE: state_in = S_DEL;
               default:    state_in = S_RESP;
            endcase
         end
         S_READ:   state_in = S_RESP;
         S_INS:    state_in = stat.ins_more ? S_INS_WR : S_RESP;
         S_INS_WR: state_in = S_INS;
         S_DEL:    state_in = stat.del_more ? S_DEL_WR : S_RESP;
         S_DEL_WR: state_in = S_DEL;
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.rd_sel = RD_POS;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
         end
         S_READ: begin
            cmd.take_read = 1'b1;
         end
         S_INS: begin
            cmd.rd_sel    = RD_PREV;
            cmd.ins_final = ~stat.ins_more;
         end
         S_INS_WR: begin
            cmd.ins_step = 1'b1;
         end
         S_DEL: begin
            cmd.rd_sel    = RD_NEXT;
            cmd.del_final = ~stat.del_more;
         end
         S_DEL_WR: begin
            cmd.del_step = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd.rd_sel = RD_POS;
         end
      endcase
   end

endmodule

// ===== hdl/indexed_sequence_store_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit
// Ordered store of signed 32-bit values with read, insert and delete by index.
//
//   channel | ports                          | direction
//   req     | req_valid req_ready req_data   | in  (operation, position, value)
//   rsp     | rsp_valid rsp_ready rsp_data   | out (read_value, status, length)
//
// One request at a time. An insert at index p shifts the elements from p to
// the end up one place, a delete at p shifts those after p down one place:
// the element RAM reads through a register, so each element moved costs a
// read and a write.
// Reset clears the element count and the sequencer, not the element RAM.
// req_ready is low from accept until the response is taken.
// ----------------------------------------------------------------------------
module indexed_sequence_store_unit import isu_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   isu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   isu_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== verif/sequence_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_store_checker
// Watches both channels of the indexed sequence store unit. Every accepted
// request is run through a local model of the ordered store, and the outcome
// is queued. Every accepted response is compared field by field with the
// oldest queued outcome. Exports the mismatch total, the number of responses
// still owed and the modeled element count.
// ----------------------------------------------------------------------------
module sequence_store_checker import isu_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned mismatch_count,
   output int unsigned awaited_count,
   output logic [6:0]  stored_count
);

   localparam int unsigned MISMATCH_SHOWN = 10;

   logic signed [31:0] seq_mem [CAPACITY];
   int unsigned        seq_len = 0;
   int unsigned        bad_total = 0;
   rsp_type            rsp_due [$];

   function automatic rsp_type apply_request(req_type r);
      rsp_type     o;
      int unsigned p;
      int unsigned i;
      bit          at_capacity;
      o           = '0;
      o.status    = ST_DONE;
      p           = r.position;
      at_capacity = (seq_len >= CAPACITY);
      case (r.operation)
         OP_READ: begin
            if (p < seq_len) begin
               o.read_value = seq_mem[p];
            end else begin
               o.read_value = READ_MISS;
               o.status     = ST_RANGE;
            end
         end
         OP_HEAD, OP_TAIL, OP_AT: begin
            if (r.operation == OP_HEAD) begin
               p = 0;
            end else if (r.operation == OP_TAIL) begin
               p = seq_len;
            end
            if (p > seq_len) begin
               o.status = ST_RANGE;
            end else if (at_capacity) begin
               o.status = ST_FULL;
            end else begin
               for (i = seq_len; i > p; i--) seq_mem[i] = seq_mem[i - 1];
               seq_mem[p] = r.value;
               seq_len++;
            end
         end
         OP_DELETE: begin
            if (p < seq_len) begin
               for (i = p; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i + 1];
               seq_len--;
            end else begin
               o.status = ST_RANGE;
            end
         end
         default: begin
            o.status = ST_RANGE;
         end
      endcase
      o.length = 7'(seq_len);
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         seq_len = 0;
         rsp_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               bad_total++;
               if (bad_total <= MISMATCH_SHOWN)
                  $display("%0t: response with no request outstanding: value %0d status %0d length %0d",
                           $time, rsp_data.read_value, rsp_data.status, rsp_data.length);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_data.read_value !== want.read_value || rsp_data.status !== want.status ||
                   rsp_data.length !== want.length) begin
                  bad_total++;
                  if (bad_total <= MISMATCH_SHOWN)
                     $display("%0t: mismatch: expected value %0d status %0d length %0d, got value %0d status %0d length %0d",
                              $time, want.read_value, want.status, want.length,
                              rsp_data.read_value, rsp_data.status, rsp_data.length);
               end
            end
         end
         if (req_valid && req_ready) rsp_due.push_back(apply_request(req_data));
      end
      mismatch_count <= bad_total;
      awaited_count  <= rsp_due.size();
      stored_count   <= 7'(seq_len);
   end

endmodule

// ===== verif/tb_indexed_sequence_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_sequence_store_unit
// Drives the indexed sequence store unit with a short directed run over the
// empty, append, range and undefined-code corners, then with random fill,
// mixed and drain sequences that push the store to full and back to empty.
// Both sides idle at random in the first two of three pacing phases, not in
// the third, and the response side holds off twice for a long stretch. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_sequence_store_unit;
   import isu_pkg::*;

   typedef enum {SEG_FILL, SEG_MIX, SEG_DRAIN} seg_type;

   localparam logic [2:0] OP_TOP_CODE  = '1;
   localparam int unsigned PHASE_ITEMS = 520;
   localparam int unsigned MIX_ITEMS   = 60;
   localparam int unsigned RUN_GUARD   = 200;
   localparam int unsigned HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   int unsigned mismatch_count;
   int unsigned awaited_count;
   logic [6:0]  stored_count;
   int unsigned snd_idle_pct = 7;
   int unsigned rcv_idle_pct = 66;

   indexed_sequence_store_unit #(.CAPACITY(CAPACITY_DEF)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sequence_store_checker #(.CAPACITY(CAPACITY_DEF)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .stored_count   (stored_count)
   );

   always #2 clock = ~clock;

   function automatic req_type make_request(logic [2:0] op, int unsigned pos,
                                            logic signed [31:0] val);
      req_type r;
      r.operation = op;
      r.position  = 7'(pos);
      r.value     = val;
      return r;
   endfunction

   function automatic req_type pick_request(seg_type seg, int unsigned cnt);
      req_type     r;
      int unsigned roll;
      r.value    = $urandom;
      r.position = (cnt == 0) ? 7'd0 : 7'($urandom_range(0, cnt - 1));
      roll       = $urandom_range(0, 99);
      case (seg)
         SEG_FILL:  r.operation = roll < 30 ? OP_HEAD : roll < 60 ? OP_TAIL :
                                  roll < 95 ? OP_AT : OP_READ;
         SEG_DRAIN: r.operation = roll < 80 ? OP_DELETE : roll < 95 ? OP_READ : OP_AT;
         default: begin
            if (roll < 25)      r.operation = OP_READ;
            else if (roll < 45) r.operation = OP_DELETE;
            else if (roll < 60) r.operation = OP_AT;
            else if (roll < 75) r.operation = OP_HEAD;
            else if (roll < 90) r.operation = OP_TAIL;
            else r.operation = 3'($urandom_range(int'(OP_DELETE) + 1, int'(OP_TOP_CODE)));
         end
      endcase
      if (r.operation == OP_AT) r.position = 7'($urandom_range(0, cnt));
      if ($urandom_range(0, 99) < 8) r.position = 7'($urandom_range(0, 127));
      return r;
   endfunction

   task automatic send_request(req_type r);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin : rsp_sink
      int unsigned taken;
      int unsigned hold_left;
      taken     = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            taken++;
            if (taken == 150 || taken == 1100) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned sent;
      int unsigned guard;
      int unsigned code;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(OP_READ, 0, 0));
      send_request(make_request(OP_DELETE, 0, 0));
      send_request(make_request(OP_AT, 1, 5));
      send_request(make_request(OP_AT, 0, 32'sh1234_5678));
      send_request(make_request(OP_TAIL, 127, 32'sh7FFF_FFFF));
      send_request(make_request(OP_HEAD, 127, 32'sh8000_0000));
      send_request(make_request(OP_AT, 3, -1));
      send_request(make_request(OP_AT, 1, 0));
      send_request(make_request(OP_AT, 6, 1));
      send_request(make_request(OP_READ, 0, -1));
      send_request(make_request(OP_READ, 4, 0));
      send_request(make_request(OP_READ, 5, 0));
      send_request(make_request(OP_READ, 127, 0));
      send_request(make_request(OP_DELETE, 127, 0));
      send_request(make_request(OP_DELETE, 5, 0));
      send_request(make_request(OP_DELETE, 2, 0));
      send_request(make_request(OP_DELETE, 3, 0));
      send_request(make_request(OP_DELETE, 0, 0));
      for (code = int'(OP_DELETE) + 1; code <= int'(OP_TOP_CODE); code++)
         send_request(make_request(3'(code), 127, -1));
      send_request(make_request(OP_READ, 0, 0));
      send_request(make_request(OP_READ, 1, 0));

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin snd_idle_pct = 7;  rcv_idle_pct = 66; end
            1:       begin snd_idle_pct = 66; rcv_idle_pct = 7;  end
            default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            for (guard = 0; stored_count < CAPACITY_DEF && guard < RUN_GUARD; guard++) begin
               send_request(pick_request(SEG_FILL, stored_count));
               sent++;
            end
            // probe the full store: head, tail, append, in range, past the end
            send_request(make_request(OP_HEAD, 0, $urandom));
            send_request(make_request(OP_TAIL, 0, $urandom));
            send_request(make_request(OP_AT, stored_count, $urandom));
            send_request(make_request(OP_AT, stored_count + 1, $urandom));
            send_request(make_request(OP_AT, $urandom_range(0, CAPACITY_DEF - 1), $urandom));
            send_request(make_request(OP_READ, CAPACITY_DEF - 1, 0));
            send_request(make_request(OP_READ, CAPACITY_DEF, 0));
            sent += 7;
            for (guard = 0; guard < MIX_ITEMS; guard++) begin
               send_request(pick_request(SEG_MIX, stored_count));
               sent++;
            end
            for (guard = 0; stored_count != 0 && guard < RUN_GUARD; guard++) begin
               send_request(pick_request(SEG_DRAIN, stored_count));
               sent++;
            end
            send_request(make_request(OP_DELETE, 0, 0));
            send_request(make_request(OP_READ, 0, 0));
            send_request(make_request(OP_AT, 1, $urandom));
            sent += 3;
            for (guard = 0; guard < MIX_ITEMS; guard++) begin
               send_request(pick_request(SEG_MIX, stored_count));
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("tb_indexed_sequence_store_unit: done, clean");
      end else begin
         $display("tb_indexed_sequence_store_unit: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("tb_indexed_sequence_store_unit: done, errors");
      $finish;
   end

endmodule
